>>> hw/rtl/rsp_pkg.sv
// Shared types, codes and constants of the RESP2 stream parser.
package rsp_pkg;

    localparam int MAX_DEPTH   = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int LVL_W       = $clog2(MAX_DEPTH + 1);
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int RQ_DEPTH    = 4;
    localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

    localparam logic [CFG_W-1:0] MAX_BULK_RST  = 32'd536870912;
    localparam logic [CFG_W-1:0] MAX_ARRAY_RST = 32'd1048576;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARRAY = 1'd1;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [LVL_W-1:0]       lvl_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [3:0] {
        M_IDLE       = 4'd0,
        M_SIMPLE     = 4'd1,
        M_ERROR      = 4'd2,
        M_INT_START  = 4'd3,
        M_INT_DIG    = 4'd4,
        M_BLEN_START = 4'd5,
        M_BLEN_DIG   = 4'd6,
        M_ALEN_START = 4'd7,
        M_ALEN_DIG   = 4'd8,
        M_INT_TAIL   = 4'd9,
        M_BLEN_TAIL  = 4'd10,
        M_ALEN_TAIL  = 4'd11,
        M_BULK_DATA  = 4'd12,
        M_BULK_TAIL  = 4'd13
    } mode_t;

    typedef enum logic [3:0] {
        EV_SIMPLE_BYTE = 4'd0,
        EV_ERROR_BYTE  = 4'd1,
        EV_BULK_BYTE   = 4'd2,
        EV_SIMPLE_END  = 4'd3,
        EV_ERROR_END   = 4'd4,
        EV_BULK_END    = 4'd5,
        EV_INTEGER     = 4'd6,
        EV_ARRAY       = 4'd7,
        EV_NULL        = 4'd8,
        EV_MALFORMED   = 4'd9
    } ev_t;

    typedef struct packed {
        logic [3:0]         event_res;
        logic [7:0]         out_byte;
        logic signed [63:0] int_value;
        logic [3:0]         nest_depth;
        logic [3:0]         levels_closed;
        logic               message_done;
        logic               last;
    } result_t;

    typedef struct packed {
        logic   clear;
        logic   pop;
        logic   push;
        count_t count;
    } stk_cmd_t;

    typedef struct packed {
        lvl_t level;
        lvl_t closed;
        logic full;
    } stk_stat_t;

    function automatic result_t mk_res(ev_t ev, logic [7:0] b, logic [63:0] v,
                                       lvl_t depth, lvl_t closed, logic done);
        result_t r;
        r.event_res     = ev;
        r.out_byte      = b;
        r.int_value     = v;
        r.nest_depth    = 4'(depth);
        r.levels_closed = 4'(closed);
        r.message_done  = done;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

>>> hw/rtl/rsp_byte_if.sv
// Input byte channel.
interface rsp_byte_if
    import rsp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/rsp_res_if.sv
// Result token channel.
interface rsp_res_if
    import rsp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [3:0]         event_res;
    logic [7:0]         out_byte;
    logic signed [63:0] int_value;
    logic [3:0]         nest_depth;
    logic [3:0]         levels_closed;
    logic               message_done;
    logic               last;

    modport source (output valid, output event_res, output out_byte, output int_value,
                    output nest_depth, output levels_closed, output message_done,
                    output last, input ready);
    modport sink   (input valid, input event_res, input out_byte, input int_value,
                    input nest_depth, input levels_closed, input message_done,
                    input last, output ready);
endinterface

>>> hw/rtl/rsp_cfg_if.sv
// Configuration write channel.
interface rsp_cfg_if
    import rsp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/resp_stream_parser_unit.sv
// Top level of the RESP2 stream parser.
//
//  channel | dir | payload                                     | accepted when
//  rx      | in  | rx_byte                                     | valid && ready
//  res     | out | event_res out_byte int_value nest_depth     | valid && ready
//          |     | levels_closed message_done last             |
//  cfg     | in  | index data                                  | valid && ready
//
// One byte per cycle while the result queue has room: a byte lands in the
// input register, is parsed by a single combinational pass once two queue
// slots are free, and its tokens are written to a four-word result queue.
// A byte yields up to two tokens; the queue drains one word per cycle while
// the receiver is ready, and parsing stalls while fewer than two slots are free.
// Reset brings the parser to idle with an empty stack; no clearing pass.
module resp_stream_parser_unit
    import rsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsp_byte_if.sink   rx,
    rsp_res_if.source  res,
    rsp_cfg_if.sink    cfg
);

    logic       space2;
    logic [1:0] wr_n;
    result_t    wr0, wr1;

    rsp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .cfg    (cfg),
        .space2 (space2),
        .wr_n   (wr_n),
        .wr0    (wr0),
        .wr1    (wr1)
    );

    rsp_resq u_resq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_n   (wr_n),
        .wr0    (wr0),
        .wr1    (wr1),
        .space2 (space2),
        .res    (res)
    );

endmodule

>>> hw/rtl/rsp_stack.sv
// Array nesting stack of remaining-element counts with parallel pop cascade.
module rsp_stack
    import rsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stk_cmd_t  cmd,
    output stk_stat_t stat
);

    lvl_t   level_reg, level_next;
    count_t cnt_reg [MAX_DEPTH];
    count_t cnt_next [MAX_DEPTH];
    lvl_t   closed;
    lvl_t   after_pop;

    // Run of entries holding one, counted down from the top of the stack.
    always_comb
    begin
        logic run;
        run    = 1'b1;
        closed = '0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--)
        begin
            if (LVL_W'(i) < level_reg)
            begin
                run = run & (cnt_reg[i] == count_t'(1));
                if (run)
                    closed = closed + lvl_t'(1);
            end
        end
    end

    assign after_pop   = level_reg - closed;
    assign stat.level  = level_reg;
    assign stat.closed = closed;
    assign stat.full   = (level_reg >= lvl_t'(MAX_DEPTH));

    always_comb
    begin
        level_next = level_reg;
        for (int i = 0; i < MAX_DEPTH; i++)
            cnt_next[i] = cnt_reg[i];
        priority if (cmd.clear)
        begin
            level_next = '0;
        end
        else if (cmd.push)
        begin
            for (int i = 0; i < MAX_DEPTH; i++)
                if (LVL_W'(i) == level_reg)
                    cnt_next[i] = cmd.count;
            level_next = level_reg + lvl_t'(1);
        end
        else if (cmd.pop)
        begin
            level_next = after_pop;
            for (int i = 0; i < MAX_DEPTH; i++)
                if (after_pop != '0 && LVL_W'(i) == after_pop - lvl_t'(1))
                    cnt_next[i] = cnt_reg[i] - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_DEPTH; i++)
            cnt_reg[i] <= cnt_next[i];
    end

endmodule

>>> hw/rtl/rsp_core.sv
// Parser core: input register, config registers, mode decode and token build.
module rsp_core
    import rsp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    rsp_byte_if.sink        rx,
    rsp_cfg_if.sink         cfg,
    input  logic            space2,
    output logic [1:0]      wr_n,
    output result_t         wr0,
    output result_t         wr1
);

    typedef struct packed {
        logic  mal;
        logic  fin;
        logic  push;
        ev_t   fin_ev;
        logic  [63:0] fin_val;
        logic  num_first;
        mode_t dig_mode;
        mode_t tail_mode;
    } act_t;

    logic        ivld_reg, ivld_next;
    logic [7:0]  byte_reg;
    logic        proc;
    logic        load;

    logic [CFG_W-1:0] max_bulk_reg;
    logic [CFG_W-1:0] max_array_reg;

    mode_t       mode_reg, mode_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        seen_reg, seen_next;
    logic        skip_reg, skip_next;
    logic        cr_reg, cr_next;
    logic [31:0] bulk_reg, bulk_next;

    stk_cmd_t    scmd;
    stk_stat_t   sstat;
    act_t        act;

    logic        is_digit;
    logic        is_sign;
    logic [63:0] acc_x10;
    logic [63:0] num_val;
    logic        is_null;
    logic        bulk_bad;
    logic        arr_bad;
    logic        line_simple;
    logic        done;
    logic [1:0]  n;
    result_t     r0, r1;

    assign load     = rx.valid && rx.ready;
    assign proc     = ivld_reg && space2;
    assign rx.ready = !ivld_reg || space2;
    assign cfg.ready = 1'b1;

    assign ivld_next = load ? 1'b1 : (proc ? 1'b0 : ivld_reg);

    assign is_digit = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign is_sign  = (byte_reg == CH_MINUS) || (byte_reg == CH_PLUS);
    assign acc_x10  = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                      + {60'd0, byte_reg[3:0]};
    assign num_val  = neg_reg ? (64'd0 - acc_reg) : acc_reg;
    assign is_null  = (num_val == '1);
    assign bulk_bad = num_val[63] || (num_val > {32'd0, max_bulk_reg});
    assign arr_bad  = num_val[63] || (num_val > {32'd0, max_array_reg})
                      || (|num_val[63:COUNT_WIDTH]);
    assign line_simple = (mode_reg == M_SIMPLE);
    assign done     = (sstat.closed == sstat.level);

    rsp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scmd),
        .stat  (sstat)
    );

    // Decode of what this byte does: malformed, value complete, or array push.
    always_comb
    begin
        act.mal       = 1'b0;
        act.fin       = 1'b0;
        act.push      = 1'b0;
        act.fin_ev    = EV_INTEGER;
        act.fin_val   = '0;
        act.num_first = 1'b0;
        act.dig_mode  = M_INT_DIG;
        act.tail_mode = M_INT_TAIL;
        unique case (mode_reg)
            M_INT_START, M_INT_DIG:
            begin
                act.num_first = (mode_reg == M_INT_START);
            end
            M_BLEN_START, M_BLEN_DIG:
            begin
                act.num_first = (mode_reg == M_BLEN_START);
                act.dig_mode  = M_BLEN_DIG;
                act.tail_mode = M_BLEN_TAIL;
            end
            M_ALEN_START, M_ALEN_DIG:
            begin
                act.num_first = (mode_reg == M_ALEN_START);
                act.dig_mode  = M_ALEN_DIG;
                act.tail_mode = M_ALEN_TAIL;
            end
            default:
            begin
            end
        endcase

        unique case (mode_reg)
            M_IDLE:
                act.mal = !(is_sign || byte_reg == CH_COLON || byte_reg == CH_DOLL
                            || byte_reg == CH_STAR);
            M_SIMPLE, M_ERROR:
            begin
                act.fin    = cr_reg && (byte_reg == CH_LF);
                act.fin_ev = line_simple ? EV_SIMPLE_END : EV_ERROR_END;
            end
            M_INT_START, M_INT_DIG, M_BLEN_START, M_BLEN_DIG, M_ALEN_START, M_ALEN_DIG:
                act.mal = !is_digit && !(act.num_first && is_sign) && !seen_reg;
            M_INT_TAIL:
            begin
                act.fin     = 1'b1;
                act.fin_ev  = EV_INTEGER;
                act.fin_val = num_val;
            end
            M_BLEN_TAIL:
            begin
                act.fin    = is_null;
                act.fin_ev = EV_NULL;
                act.mal    = !is_null && bulk_bad;
            end
            M_ALEN_TAIL:
            begin
                priority if (is_null)
                begin
                    act.fin    = 1'b1;
                    act.fin_ev = EV_NULL;
                end
                else if (arr_bad)
                    act.mal = 1'b1;
                else if (num_val == '0)
                begin
                    act.fin    = 1'b1;
                    act.fin_ev = EV_ARRAY;
                end
                else if (sstat.full)
                    act.mal = 1'b1;
                else
                    act.push = 1'b1;
            end
            M_BULK_DATA:
            begin
            end
            M_BULK_TAIL:
            begin
                act.fin    = !skip_reg;
                act.fin_ev = EV_BULK_END;
            end
            default:
                act.mal = 1'b1;
        endcase
    end

    // Next state.
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        seen_next = seen_reg;
        skip_next = skip_reg;
        cr_next   = cr_reg;
        bulk_next = bulk_reg;
        if (proc)
        begin
            if (act.mal)
            begin
                mode_next = M_IDLE;
                acc_next  = '0;
                neg_next  = 1'b0;
                seen_next = 1'b0;
                skip_next = 1'b0;
                cr_next   = 1'b0;
                bulk_next = '0;
            end
            else
            begin
                unique case (mode_reg)
                    M_IDLE:
                    begin
                        acc_next  = '0;
                        neg_next  = 1'b0;
                        seen_next = 1'b0;
                        cr_next   = 1'b0;
                        priority if (byte_reg == CH_PLUS)
                            mode_next = M_SIMPLE;
                        else if (byte_reg == CH_MINUS)
                            mode_next = M_ERROR;
                        else if (byte_reg == CH_COLON)
                            mode_next = M_INT_START;
                        else if (byte_reg == CH_DOLL)
                            mode_next = M_BLEN_START;
                        else
                            mode_next = M_ALEN_START;
                    end
                    M_SIMPLE, M_ERROR:
                    begin
                        if (cr_reg)
                        begin
                            if (byte_reg != CH_CR)
                                cr_next = 1'b0;
                            if (act.fin)
                                mode_next = M_IDLE;
                        end
                        else if (byte_reg == CH_CR)
                            cr_next = 1'b1;
                    end
                    M_INT_START, M_INT_DIG, M_BLEN_START, M_BLEN_DIG,
                    M_ALEN_START, M_ALEN_DIG:
                    begin
                        priority if (is_digit)
                        begin
                            acc_next  = acc_x10;
                            seen_next = 1'b1;
                            mode_next = act.dig_mode;
                        end
                        else if (act.num_first && is_sign)
                        begin
                            neg_next  = (byte_reg == CH_MINUS);
                            mode_next = act.dig_mode;
                        end
                        else
                            mode_next = act.tail_mode;
                    end
                    M_BLEN_TAIL:
                    begin
                        if (act.fin)
                            mode_next = M_IDLE;
                        else
                        begin
                            bulk_next = num_val[31:0];
                            skip_next = 1'b1;
                            mode_next = (num_val[31:0] != '0) ? M_BULK_DATA : M_BULK_TAIL;
                        end
                    end
                    M_BULK_DATA:
                    begin
                        bulk_next = bulk_reg - 32'd1;
                        if (bulk_reg == 32'd1)
                        begin
                            mode_next = M_BULK_TAIL;
                            skip_next = 1'b1;
                        end
                    end
                    M_BULK_TAIL:
                    begin
                        skip_next = 1'b0;
                        if (act.fin)
                            mode_next = M_IDLE;
                    end
                    default:
                        mode_next = M_IDLE;
                endcase
            end
        end
    end

    // Outputs: tokens for the result queue and stack commands.
    always_comb
    begin
        logic [3:0] cev;
        cev = line_simple ? EV_SIMPLE_BYTE : EV_ERROR_BYTE;
        n   = 2'd0;
        r0  = mk_res(EV_MALFORMED, '0, '0, sstat.level, '0, 1'b0);
        r1  = r0;
        priority if (act.mal)
            n = 2'd1;
        else if (act.fin)
        begin
            n  = 2'd1;
            r0 = mk_res(act.fin_ev, '0, act.fin_val, sstat.level, sstat.closed, done);
        end
        else if (act.push)
        begin
            n  = 2'd1;
            r0 = mk_res(EV_ARRAY, '0, num_val, sstat.level, '0, 1'b0);
        end
        else if (mode_reg == M_SIMPLE || mode_reg == M_ERROR)
        begin
            if (cr_reg)
            begin
                // Held CR goes out as content, ahead of this byte.
                r0 = mk_res(ev_t'(cev), CH_CR, '0, sstat.level, '0, 1'b0);
                r1 = mk_res(ev_t'(cev), byte_reg, '0, sstat.level, '0, 1'b0);
                n  = (byte_reg == CH_CR) ? 2'd1 : 2'd2;
            end
            else if (byte_reg != CH_CR)
            begin
                r0 = mk_res(ev_t'(cev), byte_reg, '0, sstat.level, '0, 1'b0);
                n  = 2'd1;
            end
        end
        else if (mode_reg == M_BULK_DATA)
        begin
            r0 = mk_res(EV_BULK_BYTE, byte_reg, '0, sstat.level, '0, 1'b0);
            n  = 2'd1;
        end
        r0.last = (n == 2'd1);
        r1.last = 1'b1;

        scmd.clear = proc && act.mal;
        scmd.pop   = proc && act.fin;
        scmd.push  = proc && act.push;
        scmd.count = num_val[COUNT_WIDTH-1:0];
    end

    assign wr_n = proc ? n : 2'd0;
    assign wr0  = r0;
    assign wr1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg      <= 1'b0;
            max_bulk_reg  <= MAX_BULK_RST;
            max_array_reg <= MAX_ARRAY_RST;
            mode_reg      <= M_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            cr_reg        <= 1'b0;
            bulk_reg      <= '0;
        end
        else
        begin
            ivld_reg <= ivld_next;
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            seen_reg <= seen_next;
            skip_reg <= skip_next;
            cr_reg   <= cr_next;
            bulk_reg <= bulk_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_MAX_BULK:  max_bulk_reg  <= cfg.data;
                    REG_MAX_ARRAY: max_array_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= rx.rx_byte;
    end

endmodule

>>> hw/rtl/rsp_resq.sv
// Result queue: takes up to two tokens a cycle, hands out one a cycle while the receiver is ready.
module rsp_resq
    import rsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] wr_n,
    input  result_t    wr0,
    input  result_t    wr1,
    output logic       space2,
    rsp_res_if.source  res
);

    result_t               q_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  pop;
    result_t               head;

    assign pop    = res.valid && res.ready;
    assign space2 = (cnt_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign head   = q_mem[rd_ptr_reg];

    assign res.valid         = (cnt_reg != '0);
    assign res.event_res     = head.event_res;
    assign res.out_byte      = head.out_byte;
    assign res.int_value     = head.int_value;
    assign res.nest_depth    = head.nest_depth;
    assign res.levels_closed = head.levels_closed;
    assign res.message_done  = head.message_done;
    assign res.last          = head.last;

    assign cnt_next = cnt_reg + RQ_CNT_W'(wr_n) - RQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(wr_n);
            rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_n != 2'd0)
            q_mem[wr_ptr_reg] <= wr0;
        if (wr_n == 2'd2)
            q_mem[wr_ptr_reg + RQ_PTR_W'(1)] <= wr1;
    end

endmodule

>>> hw/rtl/rsp_checker.sv
// Port-level checks of the parser, bound to the top level.
module rsp_checker
    import rsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_event,
    input logic [7:0]  out_byte,
    input logic [63:0] out_int,
    input logic [3:0]  out_closed,
    input logic        out_done,
    input logic        out_last
);

    // A stalled word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_byte)
            && $stable(out_int) && $stable(out_last))
        else $error("result word changed while stalled");

    // Content bytes never close arrays or carry a value.
    a_byte_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_event == EV_SIMPLE_BYTE || out_event == EV_ERROR_BYTE
            || out_event == EV_BULK_BYTE) |-> out_closed == '0 && !out_done && out_int == '0)
        else $error("content byte with close or value");

    // Malformed is alone for its byte and empty.
    a_mal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_event == EV_MALFORMED |-> out_last && out_byte == '0
            && out_int == '0 && out_closed == '0 && !out_done)
        else $error("malformed word not clean");

    // A non-empty array header opens a level, so closes nothing.
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_event == EV_ARRAY && out_int != '0 |-> out_closed == '0 && !out_done)
        else $error("array header closed levels");

    // Event codes stay in range.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_event <= EV_MALFORMED)
        else $error("event code out of range");

endmodule

bind resp_stream_parser_unit rsp_checker u_rsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_event  (res.event_res),
    .out_byte   (res.out_byte),
    .out_int    (res.int_value),
    .out_closed (res.levels_closed),
    .out_done   (res.message_done),
    .out_last   (res.last)
);
